FILE: design/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, constants and character helpers for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int METHOD_MAX = 16;
    localparam int PATH_MAX   = 1024;
    localparam int CNT_W      = 11;
    localparam int RES_MAX    = 4;
    localparam int CAND_N     = 8;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_METHOD = 3'b001,
        PH_PATH   = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    // Result kind as carried on the output tuser
    typedef enum logic [1:0] {
        K_METHOD_BYTE = 2'd0,
        K_PATH_BYTE   = 2'd1,
        K_METHOD_END  = 2'd2,
        K_PATH_END    = 2'd3
    } kind_t;

    // Held-escape counts
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    typedef struct packed {
        phase_t             phase;
        logic [CNT_W-1:0]   count;
        logic [1:0]         held;
        logic [7:0]         digit;
    } hrlp_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } hrlp_res_t;

    typedef struct packed {
        hrlp_res_t [RES_MAX-1:0] ent;
        logic [2:0]              num;
    } hrlp_batch_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h37;
        return v[3:0];
    endfunction

endpackage

FILE: design/hrlp_step.sv
// ----------------------------------------------------------------------------
// hrlp_step
// Per-byte step: works out the next parser state and the ordered list of up
// to four results that one request byte produces.
// ----------------------------------------------------------------------------
module hrlp_step
    import hrlp_pkg::*;
(
    input  hrlp_state_t state,
    input  logic [7:0]  in_byte,
    input  logic        is_final,
    output hrlp_state_t state_next,
    output hrlp_batch_t batch
);

    logic             in_method;
    logic             in_path;
    logic             method_end;
    logic             path_sep;
    logic             b_hex;
    logic             b_pct;
    logic [CNT_W-1:0] cnt_inc;
    logic             path_limit;
    logic             path_close;
    logic [1:0]       acc_held;
    logic [7:0]       acc_digit;
    logic [1:0]       rel_held;
    logic [7:0]       rel_digit;
    logic [7:0]       acc_byte [3];
    logic [2:0]       acc_vld;
    hrlp_res_t        cand     [CAND_N];
    logic [CAND_N-1:0] cand_vld;
    logic [2:0]       pos;
    hrlp_state_t      st_upd;

    assign in_method  = (state.phase == PH_METHOD);
    assign in_path    = (state.phase == PH_PATH);
    assign method_end = (in_byte == CH_SPACE) || (state.count >= CNT_W'(METHOD_MAX));
    assign path_sep   = in_path && ((in_byte == CH_QUERY) || (in_byte == CH_SPACE));
    assign b_hex      = is_hex(in_byte);
    assign b_pct      = (in_byte == CH_PCT);
    assign cnt_inc    = state.count + CNT_W'(1);
    assign path_limit = (cnt_inc >= CNT_W'(PATH_MAX));
    assign path_close = in_path && (path_sep || path_limit || is_final);

    // Decode the escape sequence for a path byte
    always_comb
    begin
        acc_held    = HELD_NONE;
        acc_digit   = state.digit;
        acc_vld     = 3'b000;
        acc_byte[0] = in_byte;
        acc_byte[1] = in_byte;
        acc_byte[2] = in_byte;
        unique case (state.held)
            HELD_PCT:
            begin
                if (b_hex)
                begin
                    acc_held  = HELD_DIGIT;
                    acc_digit = in_byte;
                end
                else
                begin
                    acc_byte[0] = CH_PCT;
                    acc_vld[0]  = 1'b1;
                    acc_vld[1]  = !b_pct;
                    acc_held    = b_pct ? HELD_PCT : HELD_NONE;
                end
            end
            HELD_DIGIT:
            begin
                acc_digit = 8'd0;
                if (b_hex)
                begin
                    acc_byte[0] = {hex_val(state.digit), hex_val(in_byte)};
                    acc_vld[0]  = 1'b1;
                end
                else
                begin
                    acc_byte[0] = CH_PCT;
                    acc_byte[1] = state.digit;
                    acc_vld     = {!b_pct, 2'b11};
                    acc_held    = b_pct ? HELD_PCT : HELD_NONE;
                end
            end
            default:
            begin
                acc_vld[0] = !b_pct;
                acc_held   = b_pct ? HELD_PCT : HELD_NONE;
            end
        endcase
    end

    // Release the held bytes on path close: as held on a separator, else after this byte
    assign rel_held  = path_sep ? state.held  : acc_held;
    assign rel_digit = path_sep ? state.digit : acc_digit;

    // Lay out every possible result in order
    always_comb
    begin
        cand[0]     = '{kind: method_end ? K_METHOD_END : K_METHOD_BYTE,
                        data: method_end ? 8'd0 : in_byte};
        cand_vld[0] = in_method;
        cand[1]     = '{kind: K_METHOD_END, data: 8'd0};
        cand_vld[1] = in_method && is_final && !method_end;
        cand[2]     = '{kind: K_PATH_BYTE, data: acc_byte[0]};
        cand[3]     = '{kind: K_PATH_BYTE, data: acc_byte[1]};
        cand[4]     = '{kind: K_PATH_BYTE, data: acc_byte[2]};
        cand_vld[2] = in_path && !path_sep && acc_vld[0];
        cand_vld[3] = in_path && !path_sep && acc_vld[1];
        cand_vld[4] = in_path && !path_sep && acc_vld[2];
        cand[5]     = '{kind: K_PATH_BYTE, data: CH_PCT};
        cand_vld[5] = path_close && ((rel_held == HELD_PCT) || (rel_held == HELD_DIGIT));
        cand[6]     = '{kind: K_PATH_BYTE, data: rel_digit};
        cand_vld[6] = path_close && (rel_held == HELD_DIGIT);
        cand[7]     = '{kind: K_PATH_END, data: 8'd0};
        cand_vld[7] = (in_method && is_final) || path_close;
    end

    // Pack the valid results into the first four slots, drop the rest
    always_comb
    begin
        batch.ent = '0;
        pos       = 3'd0;
        for (int i = 0; i < CAND_N; i++)
        begin
            if (cand_vld[i] && (pos < 3'(RES_MAX)))
            begin
                batch.ent[pos[1:0]] = cand[i];
                pos                 = pos + 3'd1;
            end
        end
        batch.num = pos;
    end

    // Advance the parser state
    always_comb
    begin
        st_upd = state;
        unique case (state.phase)
            PH_METHOD:
            begin
                if (method_end)
                begin
                    st_upd.phase = PH_PATH;
                    st_upd.count = '0;
                end
                else
                    st_upd.count = cnt_inc;
            end
            PH_PATH:
            begin
                if (path_close)
                begin
                    st_upd.phase = PH_DONE;
                    st_upd.held  = HELD_NONE;
                    st_upd.digit = 8'd0;
                    if (!path_sep)
                        st_upd.count = cnt_inc;
                end
                else
                begin
                    st_upd.held  = acc_held;
                    st_upd.digit = acc_digit;
                    st_upd.count = cnt_inc;
                end
            end
            default: st_upd = state;
        endcase
        if (is_final)
            state_next = '{phase: PH_METHOD, count: '0, held: HELD_NONE, digit: 8'd0};
        else
            state_next = st_upd;
    end

endmodule

FILE: design/http_request_line_parser.sv
// ----------------------------------------------------------------------------
// http_request_line_parser
// Streams a request buffer byte by byte, passes out method bytes and the
// percent-decoded path, and closes each field with an end marker.
// ----------------------------------------------------------------------------
// The first result of a byte is registered and appears in the cycle after its transfer.
// Throughput: one byte per cycle while the output is ready and each byte yields
// at most one result; a byte with more holds off input until its last is taken.
// Reset: rst_n clears the parser to the method phase and empties the
// result buffer; no results are pending after reset.
module http_request_line_parser
    import hrlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast    // run_last
);

    hrlp_state_t state_reg;
    hrlp_state_t state_next;
    hrlp_batch_t batch;
    hrlp_res_t   ent_reg [RES_MAX];
    logic [2:0]  rem_reg;
    logic [2:0]  rem_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic        in_xfer;
    logic        out_xfer;

    hrlp_step u_step (
        .state      (state_reg),
        .in_byte    (s_tdata),
        .is_final   (s_tlast),
        .state_next (state_next),
        .batch      (batch)
    );

    assign m_tvalid = (rem_reg != 3'd0);
    assign out_xfer = m_tvalid && m_tready;
    assign s_tready = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && m_tready);
    assign in_xfer  = s_tvalid && s_tready;

    assign m_tuser = ent_reg[pos_reg].kind;
    assign m_tdata = ent_reg[pos_reg].data;
    assign m_tlast = (rem_reg == 3'd1);

    // Load a fresh batch on an input transfer, else drain one per output transfer
    always_comb
    begin
        rem_next = rem_reg;
        pos_next = pos_reg;
        if (in_xfer)
        begin
            rem_next = batch.num;
            pos_next = 2'd0;
        end
        else if (out_xfer)
        begin
            rem_next = rem_reg - 3'd1;
            pos_next = pos_reg + 2'd1;
        end
    end

    // Hold parser state and buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_METHOD, count: '0, held: HELD_NONE, digit: 8'd0};
            rem_reg   <= 3'd0;
            pos_reg   <= 2'd0;
        end
        else
        begin
            if (in_xfer)
                state_reg <= state_next;
            rem_reg <= rem_next;
            pos_reg <= pos_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int i = 0; i < RES_MAX; i++)
                ent_reg[i] <= batch.ent[i];
        end
    end

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'(RES_MAX))
        else $error("result buffer count beyond capacity");

    a_final_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && s_tlast |=> state_reg.phase == PH_METHOD && state_reg.count == '0
                               && state_reg.held == HELD_NONE)
        else $error("final byte did not re-arm the parser");

    a_held_in_path: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.held != HELD_NONE |-> state_reg.phase == PH_PATH)
        else $error("escape held outside the path phase");

    a_method_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_METHOD |-> state_reg.count <= CNT_W'(METHOD_MAX))
        else $error("method count beyond limit");

    a_path_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PATH |-> state_reg.count < CNT_W'(PATH_MAX))
        else $error("path count reached limit without closing");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && m_tlast && !in_xfer |=> !m_tvalid)
        else $error("results remain after the last one was taken");

endmodule

FILE: verif/hrlp_stream_checker.sv
// ----------------------------------------------------------------------------
// hrlp_stream_checker
// Watches both stream channels of the request line parser, predicts the
// results of every input transfer and compares each output transfer against
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hrlp_stream_checker
    import hrlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_final
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic [1:0] m_tuser,   // [1:0] kind
    input  logic       m_tlast,   // run_last
    output int         fail_count,
    output int         waiting,
    output int         bytes_in,
    output int         results_out
);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } parse_res_t;

    // Results still owed by the parser, oldest first
    parse_res_t parse_results_q[$];
    // Results of the byte being predicted
    parse_res_t burst[$];

    // Predicted parser state
    phase_t           ph;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       held;
    logic [7:0]       digit;

    function automatic logic is_hex_char(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        return (c >= 8'h30 && c <= 8'h39) || (lc >= 8'h61 && lc <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (c <= 8'h39)
            return c[3:0];
        return lc[3:0] + 4'd9;
    endfunction

    function automatic void emit(input kind_t k, input logic [7:0] d);
        parse_res_t r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        if (burst.size() < RES_MAX)
            burst.push_back(r);
    endfunction

    function automatic void clear_state();
        ph    = PH_METHOD;
        cnt   = '0;
        held  = HELD_NONE;
        digit = 8'd0;
    endfunction

    // Release any held escape bytes, then mark the path complete
    function automatic void close_path();
        if (held != HELD_NONE)
            emit(K_PATH_BYTE, CH_PCT);
        if (held == HELD_DIGIT)
            emit(K_PATH_BYTE, digit);
        held  = HELD_NONE;
        digit = 8'd0;
        emit(K_PATH_END, 8'd0);
        ph = PH_DONE;
    endfunction

    // A path byte with nothing held: either start an escape or pass it out
    function automatic void plain_path(input logic [7:0] b);
        if (b == CH_PCT)
            held = HELD_PCT;
        else
            emit(K_PATH_BYTE, b);
    endfunction

    function automatic void path_char(input logic [7:0] b);
        case (held)
            HELD_PCT:
            begin
                if (is_hex_char(b))
                begin
                    held  = HELD_DIGIT;
                    digit = b;
                end
                else
                begin
                    held = HELD_NONE;
                    emit(K_PATH_BYTE, CH_PCT);
                    plain_path(b);
                end
            end
            HELD_DIGIT:
            begin
                held = HELD_NONE;
                if (is_hex_char(b))
                    emit(K_PATH_BYTE, {nibble(digit), nibble(b)});
                else
                begin
                    emit(K_PATH_BYTE, CH_PCT);
                    emit(K_PATH_BYTE, digit);
                    plain_path(b);
                end
                digit = 8'd0;
            end
            default:
            begin
                held = HELD_NONE;
                plain_path(b);
            end
        endcase
    endfunction

    // Work out the results of one accepted byte and queue them
    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        burst.delete();
        case (ph)
            PH_METHOD:
            begin
                if (b == CH_SPACE || cnt >= METHOD_MAX)
                begin
                    emit(K_METHOD_END, 8'd0);
                    ph  = PH_PATH;
                    cnt = '0;
                end
                else
                begin
                    emit(K_METHOD_BYTE, b);
                    cnt = cnt + 1'b1;
                end
            end
            PH_PATH:
            begin
                if (b == CH_QUERY || b == CH_SPACE)
                    close_path();
                else
                begin
                    path_char(b);
                    cnt = cnt + 1'b1;
                    if (cnt >= PATH_MAX)
                        close_path();
                end
            end
            default: ;
        endcase

        // Close whatever is still open on the final byte, then re-arm
        if (fin)
        begin
            if (ph == PH_METHOD)
            begin
                emit(K_METHOD_END, 8'd0);
                ph = PH_PATH;
            end
            if (ph == PH_PATH)
                close_path();
            clear_state();
        end

        if (burst.size() > 0)
            burst[burst.size()-1].last = 1'b1;
        foreach (burst[i])
            parse_results_q.push_back(burst[i]);
    endfunction

    // Predict on input transfers, score output transfers
    always @(posedge clk or negedge rst_n)
    begin
        parse_res_t want;
        if (!rst_n)
        begin
            clear_state();
            parse_results_q.delete();
            fail_count  = 0;
            waiting     = 0;
            bytes_in    = 0;
            results_out = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast);
                bytes_in++;
            end
            if (m_tvalid && m_tready)
            begin
                results_out++;
                if (parse_results_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d out_byte 0x%02h run_last %0b",
                           m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = parse_results_q.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== want.data)
                    begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("run_last: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            waiting = parse_results_q.size();
        end
    end

endmodule

FILE: verif/tb_http_request_line_parser.sv
// ----------------------------------------------------------------------------
// tb_http_request_line_parser
// Feeds the request line parser with directed and random request buffers,
// one over the method limit, under random idling on both channels and one
// long output hold-off; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_http_request_line_parser;
    import hrlp_pkg::*;

    localparam int IDLE_PCT     = 24;
    localparam int HOLD_CYCLES  = 80;
    localparam int RAND_ITEMS   = 50;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int waiting;
    int bytes_in;
    int results_out;

    // Stimulus control; calm and hold_req are shared with the sink
    bit calm;
    bit hold_req;
    int requests;
    int rand_items;

    logic [7:0] req_q[$];

    http_request_line_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    hrlp_stream_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .waiting     (waiting),
        .bytes_in    (bytes_in),
        .results_out (results_out)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Random character sources
    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return 8'(8'h30 + v);
        return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(2))
            0:       return 8'($urandom_range(8'h2F, 8'h00));
            1:       return 8'($urandom_range(8'h60, 8'h47));
            default: return 8'($urandom_range(8'hFF, 8'h67));
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h7E, 8'h21));
        while (c == CH_PCT || c == CH_QUERY);
        return c;
    endfunction

    // Append one path token: plain byte, escape, broken escape or raw byte
    function automatic void add_path_token();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            req_q.push_back(plain_char());
        else if (r < 65)
        begin
            req_q.push_back(CH_PCT);
            req_q.push_back(hex_char());
            req_q.push_back(hex_char());
        end
        else if (r < 75)
        begin
            req_q.push_back(CH_PCT);
            req_q.push_back(non_hex_char());
        end
        else if (r < 85)
        begin
            req_q.push_back(CH_PCT);
            req_q.push_back(hex_char());
            req_q.push_back(non_hex_char());
        end
        else
            req_q.push_back(8'($urandom_range(255)));
    endfunction

    // Build one random request buffer: mostly well formed, some noise
    function automatic void build_request();
        int n;
        if ($urandom_range(99) < 15)
        begin
            n = $urandom_range(8, 1);
            repeat (n) req_q.push_back(8'($urandom_range(255)));
            return;
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 15) : $urandom_range(7);
        repeat (n) req_q.push_back(8'($urandom_range(8'h5A, 8'h41)));
        if (n <= METHOD_MAX || $urandom_range(1))
            req_q.push_back(CH_SPACE);
        n = $urandom_range(10);
        repeat (n) add_path_token();
        case ($urandom_range(9))
            0, 1, 2:
            begin
                req_q.push_back(CH_QUERY);
                repeat ($urandom_range(3)) req_q.push_back(plain_char());
            end
            3, 4, 5:
            begin
                req_q.push_back(CH_SPACE);
                repeat ($urandom_range(3)) req_q.push_back(plain_char());
            end
            default: ;
        endcase
        if (req_q.size() == 0)
            req_q.push_back(plain_char());
    endfunction

    // Offer one byte and hold it until the block takes it
    task automatic push_byte(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Send the built buffer with the final flag on its last byte
    task automatic send_request();
        foreach (req_q[i])
            push_byte(req_q[i], i == req_q.size() - 1);
        requests++;
        req_q.delete();
    endtask

    // Output side: random back-pressure, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stop the run if neither channel moves for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int n;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        calm     = 1'b0;
        hold_req = 1'b0;
        requests = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: method, escapes of both cases, broken escapes, query end,
        // bytes after the path and a final byte in the done phase
        req_q = '{8'h41, 8'h20, 8'h25, 8'h34, 8'h61, 8'h25, 8'h32, 8'h46,
                  8'h25, 8'h67, 8'h25, 8'h35, 8'h25, 8'h3F, 8'h78, 8'hFF};
        send_request();
        // Directed: zero and all-ones method bytes, final with a digit held
        req_q = '{8'h00, 8'hFF, 8'h20, 8'h25, 8'h63};
        send_request();
        // Directed: empty method, empty path closed by a space, final when done
        req_q = '{8'h20, 8'h20, 8'h80};
        send_request();

        // Over the method limit, with no idling on either side
        calm = 1'b1;
        repeat (METHOD_MAX + 4) req_q.push_back(8'($urandom_range(8'h5A, 8'h41)));
        repeat (20) req_q.push_back(plain_char());
        send_request();
        calm = 1'b0;

        // Random requests; hold the output off early on to fill the block
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            if (requests == 4)
                hold_req = 1'b1;
            build_request();
            n = req_q.size();
            send_request();
            rand_items += n;
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for the output latency
        wait (waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d request buffers, %0d bytes in and %0d results checked,",
                 requests, bytes_in, results_out);
        $display("including the method limit, every escape form and final bytes in each phase.");
        if (fail_count == 0 && waiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
